/* hdl/pgt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

  // Number of gap cells in the chain.
  localparam int MaxGaps = 16;
  localparam int CntW    = $clog2(MaxGaps + 1);

  typedef enum logic [1:0] {
    KindState    = 2'd0,
    KindBalanced = 2'd1,
    KindNew      = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic CfgGain = 1'b0;
  localparam logic CfgSpan = 1'b1;

  // One stored gap.
  typedef struct packed {
    logic        valid;
    logic [31:0] low;
    logic [31:0] high;
    logic        bullish;
    logic        mitigated;
    logic        filled;
    logic [31:0] sequence_no;
    logic [47:0] origin;
  } entry_t;

  // One result, without the event time and the last marker.
  typedef struct packed {
    kind_e       kind;
    logic        bullish;
    logic [31:0] low;
    logic [31:0] high;
    logic        mitigated;
    logic        inverted;
    logic [31:0] sequence_no;
    logic [47:0] origin;
  } event_t;

  // The bar under work.
  typedef struct packed {
    logic [31:0] op;
    logic [31:0] hp;
    logic [31:0] lp;
    logic [31:0] cp;
    logic [47:0] t;
    logic [31:0] seq;
    logic [31:0] avg;
  } bar_t;

  // Candidate gap of the bar, for the balanced range pass.
  typedef struct packed {
    logic        bullish;
    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] floor_seq;
  } gap_t;

endpackage

`default_nettype wire

/* hdl/pgt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pgt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_en_i,
  input  wire pgt_pkg::entry_t shift_in_i,
  input  wire logic            ins_en_i,
  input  wire logic            prev_valid_i,
  input  wire pgt_pkg::entry_t ins_data_i,
  output pgt_pkg::entry_t      entry_o
);
  import pgt_pkg::*;

  entry_t      entry_cur, entry_d;
  logic        valid_q;
  logic [31:0] low_q;
  logic [31:0] high_q;
  logic        bullish_q;
  logic        mitigated_q;
  logic        filled_q;
  logic [31:0] sequence_q;
  logic [47:0] origin_q;
  logic        load;

  // The stored gap as one record.
  always_comb begin
    entry_cur.valid       = valid_q;
    entry_cur.low         = low_q;
    entry_cur.high        = high_q;
    entry_cur.bullish     = bullish_q;
    entry_cur.mitigated   = mitigated_q;
    entry_cur.filled      = filled_q;
    entry_cur.sequence_no = sequence_q;
    entry_cur.origin      = origin_q;
  end

  // The first empty cell after the filled ones takes a new gap.
  assign load = ins_en_i && !valid_q && prev_valid_i;

  always_comb begin
    entry_d = entry_cur;
    if (shift_en_i) begin
      entry_d = shift_in_i;
    end else if (load) begin
      entry_d = ins_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= entry_d.low;
    high_q      <= entry_d.high;
    bullish_q   <= entry_d.bullish;
    mitigated_q <= entry_d.mitigated;
    filled_q    <= entry_d.filled;
    sequence_q  <= entry_d.sequence_no;
    origin_q    <= entry_d.origin;
  end

  assign entry_o = entry_cur;

endmodule

`default_nettype wire

/* hdl/pgt_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module pgt_eval (
  input  wire pgt_pkg::entry_t head_i,
  input  wire logic            bal_pass_i,
  input  wire pgt_pkg::bar_t   bar_i,
  input  wire pgt_pkg::gap_t   gap_i,
  output pgt_pkg::entry_t      entry_o,
  output logic                 hit_o,
  output pgt_pkg::event_t      event_o
);
  import pgt_pkg::*;

  logic [32:0] mid2;
  logic [32:0] lo2;
  logic [32:0] hi2;
  logic        mit_hit;
  logic        broken;
  logic        live;
  logic [31:0] olo;
  logic [31:0] ohi;
  logic        overlap;

  assign mid2 = {1'b0, head_i.low} + {1'b0, head_i.high};
  assign lo2  = {bar_i.lp, 1'b0};
  assign hi2  = {bar_i.hp, 1'b0};
  assign live = head_i.valid && !head_i.filled;

  // Midpoint touch and far edge break of a stored gap.
  assign mit_hit = !head_i.mitigated && (lo2 <= mid2) && (mid2 <= hi2);
  assign broken  = head_i.bullish ? (bar_i.cp < head_i.low) : (bar_i.cp > head_i.high);

  // Overlap with the candidate gap.
  assign olo     = (head_i.low > gap_i.low) ? head_i.low : gap_i.low;
  assign ohi     = (head_i.high < gap_i.high) ? head_i.high : gap_i.high;
  assign overlap = head_i.valid && (head_i.bullish != gap_i.bullish) &&
                   (head_i.sequence_no >= gap_i.floor_seq) && (olo <= ohi);

  always_comb begin
    entry_o = head_i;
    hit_o   = 1'b0;
    event_o = '0;
    if (bal_pass_i) begin
      hit_o               = overlap;
      event_o.kind        = KindBalanced;
      event_o.bullish     = gap_i.bullish;
      event_o.low         = olo;
      event_o.high        = ohi;
      event_o.sequence_no = bar_i.seq;
      event_o.origin      = bar_i.t;
    end else begin
      if (live) begin
        entry_o.mitigated = head_i.mitigated || mit_hit || broken;
        entry_o.filled    = broken;
        hit_o             = mit_hit || broken;
      end
      event_o.kind        = KindState;
      event_o.bullish     = head_i.bullish;
      event_o.low         = head_i.low;
      event_o.high        = head_i.high;
      event_o.mitigated   = entry_o.mitigated;
      event_o.inverted    = entry_o.filled;
      event_o.sequence_no = head_i.sequence_no;
      event_o.origin      = head_i.origin;
    end
  end

endmodule

`default_nettype wire

/* hdl/price_gap_tracker_core.sv */
// Steps: a bar is taken in StIdle; the gap state pass walks the cell chain, then StDet
// and StDec decide on a new gap; if one formed, a balanced range pass over the chain
// and an insert step follow, and StFlush closes the bar. Results leave one per cycle;
// output stall pauses the chain. Reset clears the prior bars, the cell valid bits and
// the registers to 1.5 gain and a span of 10; cell payloads are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module price_gap_tracker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] open_price_i,
  input  wire logic [31:0] high_price_i,
  input  wire logic [31:0] low_price_i,
  input  wire logic [31:0] close_price_i,
  input  wire logic [47:0] open_time_i,
  input  wire logic [31:0] bar_sequence_i,
  input  wire logic [31:0] avg_body_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       event_kind_o,
  output logic             bullish_o,
  output logic [31:0]      range_low_o,
  output logic [31:0]      range_high_o,
  output logic             is_mitigated_o,
  output logic             is_inverted_o,
  output logic [31:0]      gap_sequence_o,
  output logic [47:0]      origin_time_o,
  output logic [47:0]      event_time_o,
  output logic             last_event_o
);
  import pgt_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StUpd, StDet, StDec, StBal, StIns, StFlush
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] gain_q, gain_d;
  logic [15:0] span_q, span_d;
  bar_t        bar_q, bar_d;
  gap_t        gap_q, gap_d;
  logic [31:0] ph_q [2], ph_d [2];
  logic [31:0] pl_q [2], pl_d [2];
  logic [31:0] po_q [2], po_d [2];
  logic [31:0] pc_q [2], pc_d [2];
  logic [47:0] pt_q [2], pt_d [2];
  logic [1:0]  seen_q, seen_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0] body_q, body_d;
  logic [43:0] prod_q, prod_d;
  event_t      pend_q, pend_d;
  logic        pend_v_q, pend_v_d;
  event_t      out_q, out_d;
  logic        last_q, last_d;
  logic        ovalid_q, ovalid_d;
  logic [47:0] etime_q, etime_d;

  entry_t      cells [MaxGaps];
  entry_t      upd_entry;
  entry_t      new_entry;
  entry_t      tail;
  event_t      ev;
  event_t      emit_ev;
  logic        ev_hit;
  logic        emit_v;
  logic        adv;
  logic        full;
  logic        shift_en;
  logic        ins_en;
  logic        big;
  logic        bull_found;
  logic        bear_found;

  assign adv  = !ovalid_q || !out_stall_i;
  assign full = cells[MaxGaps-1].valid;

  pgt_eval u_eval (
    .head_i     (cells[0]),
    .bal_pass_i (state_q == StBal),
    .bar_i      (bar_q),
    .gap_i      (gap_q),
    .entry_o    (upd_entry),
    .hit_o      (ev_hit),
    .event_o    (ev)
  );

  // Gap formed by this bar, as stored in the chain.
  always_comb begin
    new_entry             = '0;
    new_entry.valid       = 1'b1;
    new_entry.low         = gap_q.low;
    new_entry.high        = gap_q.high;
    new_entry.bullish     = gap_q.bullish;
    new_entry.sequence_no = bar_q.seq;
    new_entry.origin      = pt_q[0];
  end

  assign shift_en = (((state_q == StUpd) || (state_q == StBal)) && adv) ||
                    ((state_q == StIns) && adv && full);
  assign ins_en   = (state_q == StIns) && adv && !full;
  assign tail     = (state_q == StIns) ? new_entry : upd_entry;

  // The chain rotates toward cell 0; the head goes through the evaluator to the tail.
  for (genvar g = 0; g < MaxGaps; g++) begin : g_cell
    entry_t nb;
    logic   pv;
    if (g == MaxGaps - 1) begin : g_last
      assign nb = tail;
    end else begin : g_mid
      assign nb = cells[g+1];
    end
    if (g == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_rest
      assign pv = cells[g-1].valid;
    end
    pgt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_en_i   (shift_en),
      .shift_in_i   (nb),
      .ins_en_i     (ins_en),
      .prev_valid_i (pv),
      .ins_data_i   (new_entry),
      .entry_o      (cells[g])
    );
  end

  // Displacement test and gap shapes.
  assign big        = {4'b0, body_q, 8'b0} >= prod_q;
  assign bull_found = (ph_q[0] < bar_q.lp) && (pc_q[1] > po_q[1]) && big;
  assign bear_found = (pl_q[0] > bar_q.hp) && (pc_q[1] < po_q[1]) && big;

  // Results produced in this cycle.
  always_comb begin
    emit_v  = 1'b0;
    emit_ev = ev;
    if (((state_q == StUpd) || (state_q == StBal)) && adv && ev_hit) begin
      emit_v = 1'b1;
    end else if ((state_q == StIns) && adv) begin
      emit_v              = 1'b1;
      emit_ev             = '0;
      emit_ev.kind        = KindNew;
      emit_ev.bullish     = gap_q.bullish;
      emit_ev.low         = gap_q.low;
      emit_ev.high        = gap_q.high;
      emit_ev.sequence_no = bar_q.seq;
      emit_ev.origin      = pt_q[0];
    end
  end

  always_comb begin
    state_d  = state_q;
    gain_d   = gain_q;
    span_d   = span_q;
    bar_d    = bar_q;
    gap_d    = gap_q;
    ph_d     = ph_q;
    pl_d     = pl_q;
    po_d     = po_q;
    pc_d     = pc_q;
    pt_d     = pt_q;
    seen_d   = seen_q;
    cnt_d    = cnt_q;
    body_d   = body_q;
    prod_d   = prod_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    last_d   = last_q;
    ovalid_d = ovalid_q && out_stall_i;
    etime_d  = etime_q;

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGain: gain_d = cfg_data_i[11:0];
        CfgSpan: span_d = cfg_data_i;
        default: ;
      endcase
    end

    // One result is held back so that the last one of a bar can be marked.
    if (emit_v) begin
      pend_d   = emit_ev;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_d    = pend_q;
        last_d   = 1'b0;
        ovalid_d = 1'b1;
        etime_d  = bar_q.t;
      end
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bar_d.op  = open_price_i;
          bar_d.hp  = high_price_i;
          bar_d.lp  = low_price_i;
          bar_d.cp  = close_price_i;
          bar_d.t   = open_time_i;
          bar_d.seq = bar_sequence_i;
          bar_d.avg = avg_body_i;
          cnt_d     = '0;
          state_d   = StUpd;
        end
      end
      StUpd, StBal: begin
        if (adv) begin
          if (cnt_q == CntW'(MaxGaps - 1)) begin
            cnt_d   = '0;
            state_d = (state_q == StUpd) ? StDet : StIns;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StDet: begin
        body_d  = (pc_q[1] >= po_q[1]) ? (pc_q[1] - po_q[1]) : (po_q[1] - pc_q[1]);
        prod_d  = 44'(gain_q) * 44'(bar_q.avg);
        state_d = StDec;
      end
      StDec: begin
        gap_d.bullish   = bull_found;
        gap_d.low       = bull_found ? ph_q[0] : bar_q.hp;
        gap_d.high      = bull_found ? bar_q.lp : pl_q[0];
        gap_d.floor_seq = (bar_q.seq > {16'b0, span_q}) ? (bar_q.seq - {16'b0, span_q})
                                                         : 32'd0;
        if ((seen_q == 2'd2) && (bull_found || bear_found)) begin
          state_d = StBal;
        end else begin
          state_d = StFlush;
        end
      end
      StIns: begin
        if (adv) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!pend_v_q || adv) begin
          if (pend_v_q) begin
            out_d    = pend_q;
            last_d   = 1'b1;
            ovalid_d = 1'b1;
            etime_d  = bar_q.t;
            pend_v_d = 1'b0;
          end
          ph_d[0] = ph_q[1];
          pl_d[0] = pl_q[1];
          po_d[0] = po_q[1];
          pc_d[0] = pc_q[1];
          pt_d[0] = pt_q[1];
          ph_d[1] = bar_q.hp;
          pl_d[1] = bar_q.lp;
          po_d[1] = bar_q.op;
          pc_d[1] = bar_q.cp;
          pt_d[1] = bar_q.t;
          if (seen_q != 2'd2) begin
            seen_d = seen_q + 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      gain_q   <= 12'd384;
      span_q   <= 16'd10;
      seen_q   <= 2'd0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      ovalid_q <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        ph_q[k] <= '0;
        pl_q[k] <= '0;
        po_q[k] <= '0;
        pc_q[k] <= '0;
        pt_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      gain_q   <= gain_d;
      span_q   <= span_d;
      seen_q   <= seen_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      ovalid_q <= ovalid_d;
      ph_q     <= ph_d;
      pl_q     <= pl_d;
      po_q     <= po_d;
      pc_q     <= pc_d;
      pt_q     <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bar_q   <= bar_d;
    gap_q   <= gap_d;
    body_q  <= body_d;
    prod_q  <= prod_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
    last_q  <= last_d;
    etime_q <= etime_d;
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = ovalid_q;
  assign event_kind_o   = out_q.kind;
  assign bullish_o      = out_q.bullish;
  assign range_low_o    = out_q.low;
  assign range_high_o   = out_q.high;
  assign is_mitigated_o = out_q.mitigated;
  assign is_inverted_o  = out_q.inverted;
  assign gap_sequence_o = out_q.sequence_no;
  assign origin_time_o  = out_q.origin;
  assign event_time_o   = etime_q;
  assign last_event_o   = last_q;

endmodule

`default_nettype wire
